// ===== design/assert_macros.svh =====
// assertion helpers used by the top level to check its own logic
// depends on nothing; expects signals named clock and reset in the using module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/dpw_pkg.sv =====
// shared types, constants and helpers of the depth pixel to world point block
// depends on nothing
package dpw_pkg;

   localparam int COORD_BITS_DEFAULT = 12;
   localparam int COORD_IN_BITS      = 12;
   localparam int COORD_MAX_BITS     = 16;

   localparam int DEPTH_BITS = 16;
   localparam int MASK_BITS  = 8;
   localparam int Z_BITS     = 23;
   localparam int LEVEL_BITS = 17;
   localparam int CAM_MAG_BITS = 39;
   localparam int TERM_BITS  = 44;
   localparam int PAIR_BITS  = 45;
   localparam int SUM_BITS   = 46;

   localparam int REG_COUNT     = 8;
   localparam int REG_IDX_BITS  = 3;
   localparam int CSR_ADDR_BITS = 6;
   localparam int CSR_DATA_BITS = 64;

   // depth*65536/1000 rounded == floor((depth*8192 + 62) / 125)
   localparam logic [12:0] Z_BIAS   = 13'd62;
   localparam logic [29:0] Z_RECIP  = 30'd549755814;
   localparam int          Z_SHIFT  = 36;
   // floor(x / 3) for x below 2^23
   localparam logic [23:0] THIRD_RECIP = 24'd11184811;
   localparam int          THIRD_SHIFT = 25;
   localparam int          BLUE_RAW_BITS = 22;
   localparam logic [LEVEL_BITS-1:0] ONE_Q16 = 17'd65536;

   typedef enum logic [REG_IDX_BITS-1:0] {
      REG_R0_C01,
      REG_R0_C23,
      REG_R1_C01,
      REG_R1_C23,
      REG_R2_C01,
      REG_R2_C23,
      REG_INV_FOCAL,
      REG_PRINCIPAL
   } reg_index_type;

   typedef struct packed {
      logic [31:0] inv_fx;
      logic [31:0] inv_fy;
      logic [31:0] cx;
      logic [31:0] cy;
   } cam_cfg_type;

   typedef struct packed {
      logic [2:0][2:0][31:0] m;
      logic [2:0][31:0]      t;
   } pose_cfg_type;

   typedef struct packed {
      logic signed [31:0]    x;
      logic signed [31:0]    y;
      logic [Z_BITS-1:0]     z;
      logic [LEVEL_BITS-1:0] red;
      logic [LEVEL_BITS-1:0] blue;
   } cam_point_type;

   typedef struct packed {
      logic [LEVEL_BITS-1:0] blue;
      logic [LEVEL_BITS-1:0] red;
      logic signed [31:0]    z;
      logic signed [31:0]    y;
      logic signed [31:0]    x;
   } world_point_type;

   function automatic logic [CSR_DATA_BITS-1:0] csr_reset_value(input reg_index_type idx);
      logic [CSR_DATA_BITS-1:0] v;
      case (idx)
         REG_R0_C01: v = 64'h0000_0000_0010_0000;
         REG_R1_C01: v = 64'h0010_0000_0000_0000;
         REG_R2_C23: v = 64'h0000_0000_0010_0000;
         default:    v = '0;
      endcase
      return v;
   endfunction

   // signed magnitude to Q16.16 with saturation
   function automatic logic signed [31:0] sat_mag(input logic [CAM_MAG_BITS-1:0] mag,
                                                  input logic neg);
      logic signed [31:0] r;
      if (neg) begin
         if (mag >= CAM_MAG_BITS'(33'h0_8000_0000)) r = 32'sh8000_0000;
         else r = -$signed(mag[31:0]);
      end else begin
         if (mag > CAM_MAG_BITS'(32'h7FFF_FFFF)) r = 32'sh7FFF_FFFF;
         else r = $signed(mag[31:0]);
      end
      return r;
   endfunction

   function automatic logic signed [31:0] sat_sum(input logic signed [SUM_BITS-1:0] v);
      logic signed [31:0] r;
      if (v > SUM_BITS'(32'sh7FFF_FFFF)) r = 32'sh7FFF_FFFF;
      else if (v < SUM_BITS'(32'sh8000_0000)) r = 32'sh8000_0000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

// ===== design/depth_pixel_to_world_point.sv =====
// top level of the depth pixel to world point block: register file, pipeline control
// depends on dpw_pkg, dpw_cam, dpw_pose and assert_macros.svh
`include "assert_macros.svh"

// Turns one depth pixel per clock, when not stalled, into a world point (Q16.16 meters,
// saturated) and a red/blue depth ramp (Q1.16). A pixel with zero depth or a zero mask
// byte is taken and produces no transaction on the result side. The pipeline has seven
// register stages: four in the camera part (depth scale and pixel offset, reciprocal
// focal multiply, depth multiply, saturation) and three in the pose part (nine 32x32
// products, rounding and pair sums, final sum and saturation). One pixel can be taken
// in every cycle that is not a stall. The whole pipeline moves together: it stalls only
// while the output register holds a result that rsp_tready has not taken, so req_tready
// follows rsp_tready combinationally in that case. Configuration registers are 64 bits
// at byte address 8*i and are read live by the pipeline, so they are written only while
// no pixel is in flight, a rule on the user that the block itself does not enforce.
module depth_pixel_to_world_point
   import dpw_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   // pixel input
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // [15:0] depth, [23:16] valid_mask, [35:24] col, [47:36] row
   input  logic [47:0]              req_tdata,
   // world point output
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // [31:0] world_x, [63:32] world_y, [95:64] world_z, [112:96] red_level,
   // [129:113] blue_level, [135:130] zero
   output logic [135:0]             rsp_tdata,
   // register port
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   // register file
   logic [CSR_DATA_BITS-1:0] csr_ff [REG_COUNT];
   logic [CSR_DATA_BITS-1:0] csr_in [REG_COUNT];
   logic [REG_IDX_BITS-1:0]  csr_idx;
   logic                     csr_write;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_ADDR_BITS-1 -: REG_IDX_BITS];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_ff[csr_idx];

   always_comb begin
      for (int i = 0; i < REG_COUNT; i++) begin
         csr_in[i] = csr_ff[i];
      end
      if (csr_write) begin
         csr_in[csr_idx] = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            csr_ff[i] <= csr_reset_value(reg_index_type'(i));
         end
      end else begin
         for (int i = 0; i < REG_COUNT; i++) begin
            csr_ff[i] <= csr_in[i];
         end
      end
   end

   // unpack registers for the two pipeline halves
   cam_cfg_type  cam_cfg;
   pose_cfg_type pose_cfg;

   always_comb begin
      cam_cfg.inv_fx = csr_ff[REG_INV_FOCAL][31:0];
      cam_cfg.inv_fy = csr_ff[REG_INV_FOCAL][63:32];
      cam_cfg.cx     = csr_ff[REG_PRINCIPAL][31:0];
      cam_cfg.cy     = csr_ff[REG_PRINCIPAL][63:32];
      for (int i = 0; i < 3; i++) begin
         pose_cfg.m[i][0] = csr_ff[REG_IDX_BITS'(2 * i)][31:0];
         pose_cfg.m[i][1] = csr_ff[REG_IDX_BITS'(2 * i)][63:32];
         pose_cfg.m[i][2] = csr_ff[REG_IDX_BITS'(2 * i + 1)][31:0];
         pose_cfg.t[i]    = csr_ff[REG_IDX_BITS'(2 * i + 1)][63:32];
      end
   end

   // input fields
   logic [DEPTH_BITS-1:0]    pix_depth;
   logic [MASK_BITS-1:0]     valid_mask;
   logic [COORD_IN_BITS-1:0] col, row;
   logic                     pixel_used;

   assign pix_depth  = req_tdata[15:0];
   assign valid_mask = req_tdata[23:16];
   assign col        = req_tdata[35:24];
   assign row        = req_tdata[47:36];
   // pixels without depth or masked off are consumed and dropped at the door
   assign pixel_used = req_tvalid && (pix_depth != '0) && (valid_mask != '0);

   // one enable for every stage: advance unless the output holds an untaken result
   logic pipe_en;
   assign pipe_en    = !rsp_tvalid || rsp_tready;
   assign req_tready = pipe_en;

   logic            cam_valid;
   cam_point_type   cam_point;
   world_point_type world_point;

   dpw_cam #(
      .COORD_BITS(COORD_BITS)
   ) u_cam (
      .clock      (clock),
      .reset      (reset),
      .en         (pipe_en),
      .in_valid   (pixel_used),
      .depth      (pix_depth),
      .col        (col),
      .row        (row),
      .cfg        (cam_cfg),
      .point_valid(cam_valid),
      .point      (cam_point)
   );

   dpw_pose u_pose (
      .clock    (clock),
      .reset    (reset),
      .en       (pipe_en),
      .in_valid (cam_valid),
      .point    (cam_point),
      .cfg      (pose_cfg),
      .out_valid(rsp_tvalid),
      .out_point(world_point)
   );

   assign rsp_tdata = {6'd0, world_point};

   // color ramp channels always sum to one
   logic [LEVEL_BITS:0] ramp_sum;
   assign ramp_sum = (LEVEL_BITS + 1)'(world_point.red) + (LEVEL_BITS + 1)'(world_point.blue);

   `ASSERT_NOW(a_stall_cause, !req_tready, rsp_tvalid && !rsp_tready, "stall without backpressure")
   `ASSERT_NEXT(a_cam_hold, cam_valid && !req_tready, cam_valid, "camera stage lost a point in a stall")
   `ASSERT_NOW(a_ramp_sum, rsp_tvalid, ramp_sum == (LEVEL_BITS + 1)'(ONE_Q16), "red plus blue is not one")

endmodule

// ===== design/dpw_cam.sv =====
// camera back-projection pipeline: depth to meters, pinhole lift, color ramp
// depends on dpw_pkg
module dpw_cam
   import dpw_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic [DEPTH_BITS-1:0]    depth,
   input  logic [COORD_IN_BITS-1:0] col,
   input  logic [COORD_IN_BITS-1:0] row,
   input  cam_cfg_type              cfg,
   output logic                     point_valid,
   output cam_point_type            point
);

   localparam logic [COORD_MAX_BITS-1:0] CoordMask =
      COORD_MAX_BITS'((32'd1 << COORD_BITS) - 32'd1);

   // stage 1: depth scale, pixel offsets
   logic [COORD_MAX_BITS-1:0] u, v;
   logic [28:0]               depth_a;
   logic [58:0]               z_prod;
   logic signed [33:0]        du, dv;
   logic                      s1_valid_ff;
   logic [Z_BITS-1:0]         s1_z_ff;
   logic [31:0]               s1_magx_ff, s1_magy_ff;
   logic                      s1_negx_ff, s1_negy_ff;

   always_comb begin
      u       = COORD_MAX_BITS'(col) & CoordMask;
      v       = COORD_MAX_BITS'(row) & CoordMask;
      depth_a = 29'({depth, 13'd0}) + 29'(Z_BIAS);
      z_prod  = 59'(depth_a) * 59'(Z_RECIP);
      du      = $signed({2'b00, u, 16'h0000}) - $signed({2'b00, cfg.cx});
      dv      = $signed({2'b00, v, 16'h0000}) - $signed({2'b00, cfg.cy});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
      end
      if (en) begin
         s1_z_ff    <= z_prod[Z_SHIFT +: Z_BITS];
         s1_negx_ff <= du[33];
         s1_negy_ff <= dv[33];
         s1_magx_ff <= du[33] ? 32'(-du) : du[31:0];
         s1_magy_ff <= dv[33] ? 32'(-dv) : dv[31:0];
      end
   end

   // stage 2: normalized image coordinates, color ramp divide
   logic [63:0]              nx_prod, ny_prod;
   logic [46:0]              blue_prod;
   logic                     s2_valid_ff;
   logic [31:0]              s2_nx_ff, s2_ny_ff;
   logic                     s2_negx_ff, s2_negy_ff;
   logic [Z_BITS-1:0]        s2_z_ff;
   logic [BLUE_RAW_BITS-1:0] s2_blue_ff;

   always_comb begin
      nx_prod   = 64'(s1_magx_ff) * 64'(cfg.inv_fx) + 64'h0000_0000_8000_0000;
      ny_prod   = 64'(s1_magy_ff) * 64'(cfg.inv_fy) + 64'h0000_0000_8000_0000;
      blue_prod = 47'(s1_z_ff + Z_BITS'(1)) * 47'(THIRD_RECIP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (en) begin
         s2_nx_ff   <= nx_prod[63:32];
         s2_ny_ff   <= ny_prod[63:32];
         s2_negx_ff <= s1_negx_ff;
         s2_negy_ff <= !s1_negy_ff; // image y axis points down
         s2_z_ff    <= s1_z_ff;
         s2_blue_ff <= blue_prod[THIRD_SHIFT +: BLUE_RAW_BITS];
      end
   end

   // stage 3: scale by depth, clamp ramp
   logic [54:0]             cx_prod, cy_prod;
   logic [LEVEL_BITS-1:0]   blue_clamp;
   logic                    s3_valid_ff;
   logic [CAM_MAG_BITS-1:0] s3_cx_ff, s3_cy_ff;
   logic                    s3_negx_ff, s3_negy_ff;
   logic [Z_BITS-1:0]       s3_z_ff;
   logic [LEVEL_BITS-1:0]   s3_red_ff, s3_blue_ff;

   always_comb begin
      cx_prod = 55'(s2_nx_ff) * 55'(s2_z_ff) + 55'h8000;
      cy_prod = 55'(s2_ny_ff) * 55'(s2_z_ff) + 55'h8000;
      if (s2_blue_ff > BLUE_RAW_BITS'(ONE_Q16)) blue_clamp = ONE_Q16;
      else blue_clamp = s2_blue_ff[LEVEL_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (en) begin
         s3_cx_ff   <= cx_prod[54:16];
         s3_cy_ff   <= cy_prod[54:16];
         s3_negx_ff <= s2_negx_ff;
         s3_negy_ff <= s2_negy_ff;
         s3_z_ff    <= s2_z_ff;
         s3_blue_ff <= blue_clamp;
         s3_red_ff  <= ONE_Q16 - blue_clamp;
      end
   end

   // stage 4: signed, saturated camera point
   logic          s4_valid_ff;
   cam_point_type s4_point_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s4_valid_ff <= s3_valid_ff;
      end
      if (en) begin
         s4_point_ff.x    <= sat_mag(s3_cx_ff, s3_negx_ff);
         s4_point_ff.y    <= sat_mag(s3_cy_ff, s3_negy_ff);
         s4_point_ff.z    <= s3_z_ff;
         s4_point_ff.red  <= s3_red_ff;
         s4_point_ff.blue <= s3_blue_ff;
      end
   end

   assign point_valid = s4_valid_ff;
   assign point       = s4_point_ff;

endmodule

// ===== design/dpw_pose.sv =====
// rigid pose transform pipeline: 3x3 rotation times camera point plus translation
// depends on dpw_pkg
module dpw_pose
   import dpw_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_valid,
   input  cam_point_type   point,
   input  pose_cfg_type    cfg,
   output logic            out_valid,
   output world_point_type out_point
);

   // stage 5: nine products
   logic signed [2:0][31:0]       cam;
   logic signed [2:0][2:0][63:0]  prod;
   logic                          s5_valid_ff;
   logic signed [2:0][2:0][63:0]  s5_prod_ff;
   logic [LEVEL_BITS-1:0]         s5_red_ff, s5_blue_ff;

   always_comb begin
      cam[0] = point.x;
      cam[1] = point.y;
      cam[2] = $signed(32'(point.z));
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod[i][j] = 64'($signed(cfg.m[i][j])) * 64'($signed(cam[j]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (en) begin
         s5_valid_ff <= in_valid;
      end
      if (en) begin
         s5_prod_ff <= prod;
         s5_red_ff  <= point.red;
         s5_blue_ff <= point.blue;
      end
   end

   // stage 6: round each term, pairwise sums
   logic signed [63:0]                 rnd;
   logic signed [2:0][2:0][TERM_BITS-1:0] term;
   logic signed [32:0]                 t_rnd;
   logic signed [2:0][28:0]            t_term;
   logic signed [2:0][PAIR_BITS-1:0]   pair_a, pair_b;
   logic                               s6_valid_ff;
   logic signed [2:0][PAIR_BITS-1:0]   s6_pair_a_ff, s6_pair_b_ff;
   logic [LEVEL_BITS-1:0]              s6_red_ff, s6_blue_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            rnd        = s5_prod_ff[i][j] + 64'sd524288;
            term[i][j] = rnd[63:20];
         end
         t_rnd     = 33'($signed(cfg.t[i])) + 33'sd8;
         t_term[i] = t_rnd[32:4];
         pair_a[i] = PAIR_BITS'($signed(term[i][0])) + PAIR_BITS'($signed(term[i][1]));
         pair_b[i] = PAIR_BITS'($signed(term[i][2])) + PAIR_BITS'($signed(t_term[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (en) begin
         s6_valid_ff <= s5_valid_ff;
      end
      if (en) begin
         s6_pair_a_ff <= pair_a;
         s6_pair_b_ff <= pair_b;
         s6_red_ff    <= s5_red_ff;
         s6_blue_ff   <= s5_blue_ff;
      end
   end

   // stage 7: final sum, saturate, output register
   logic signed [2:0][SUM_BITS-1:0] sum;
   logic                            s7_valid_ff;
   world_point_type                 s7_point_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum[i] = SUM_BITS'($signed(s6_pair_a_ff[i])) + SUM_BITS'($signed(s6_pair_b_ff[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff <= 1'b0;
      end else if (en) begin
         s7_valid_ff <= s6_valid_ff;
      end
      if (en) begin
         s7_point_ff.x    <= sat_sum(sum[0]);
         s7_point_ff.y    <= sat_sum(sum[1]);
         s7_point_ff.z    <= sat_sum(sum[2]);
         s7_point_ff.red  <= s6_red_ff;
         s7_point_ff.blue <= s6_blue_ff;
      end
   end

   assign out_valid = s7_valid_ff;
   assign out_point = s7_point_ff;

endmodule
